// ===== sv/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Holds the function codes, the controller/datapath command and status structs
// and the fixed field widths. No dependencies.
package tcw_pkg;

  localparam int MAX_COLS_DEF  = 80;
  localparam int MAX_ROWS_DEF  = 25;
  localparam int TAB_WIDTH_DEF = 4;

  // Cursor is kept one bit wider than the port so that a tab run can step past it.
  localparam int CUR_W = 12;
  localparam int DIV_W = CUR_W;
  localparam int COL_W = 7;
  localparam int ROW_W = 5;

  localparam logic [COL_W-1:0] COLS_RESET = 7'd80;
  localparam logic [ROW_W-1:0] ROWS_RESET = 5'd25;

  localparam logic [2:0] FN_PUTC  = 3'd0;
  localparam logic [2:0] FN_BKSP  = 3'd1;
  localparam logic [2:0] FN_SEEK  = 3'd2;
  localparam logic [2:0] FN_SETXY = 3'd3;
  localparam logic [2:0] FN_COLOR = 3'd4;
  localparam logic [2:0] FN_CLS   = 3'd5;
  localparam logic [2:0] FN_READ  = 3'd6;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MARK  = 8'h5f;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] ATTR_PLAIN = 8'h07;

  localparam logic [0:0] CFG_COLS = 1'b0;
  localparam logic [0:0] CFG_ROWS = 1'b1;

  typedef enum logic [2:0] {
    WK_NONE, WK_CUR_BLANK, WK_CUR_CHAR, WK_CUR_MARK, WK_PTR_BLANK, WK_PTR_COPY
  } wk_e;

  typedef enum logic [2:0] {
    CUR_HOLD, CUR_INC, CUR_DEC, CUR_IDX, CUR_PROD, CUR_XY, CUR_MASK
  } cur_op_e;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_ZERO, PTR_COLS, PTR_LINE, PTR_INC
  } ptr_op_e;

  typedef struct packed {
    logic    latch;
    wk_e     wr_kind;
    logic    rd_ptr;
    cur_op_e cur_op;
    ptr_op_e ptr_op;
    logic    attr_load;
    logic    err_set;
    logic    cell_load;
    logic    nl_row_load;
    logic    div_start;
    logic    div_out;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       is_nl;
    logic       is_tab;
    logic       cur_zero;
    logic       idx_bad;
    logic       xy_bad;
    logic       pp_wrap;
    logic       scroll;
    logic       copy_empty;
    logic       ptr_last;
    logic       ptr_last_all;
    logic       div_done;
  } sts_t;

endpackage

// ===== sv/text_console_writer.sv =====
// Text console writer: one result per transaction, one transaction at a time.
// Every transaction ends with the serial row/column divider before its result is loaded;
// clear screen sweeps the area in use to blanks, and a newline on the last line scrolls
// the screen up and clears the last line. After reset the whole store is swept to blanks
// with in_ready_o low; configuration writes are taken throughout.
module text_console_writer import tcw_pkg::*; #(
  parameter int MaxCols  = MAX_COLS_DEF,
  parameter int MaxRows  = MAX_ROWS_DEF,
  parameter int TabWidth = TAB_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_index_i,
  input  logic [COL_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       func_i,
  input  logic [7:0]       ch_i,
  input  logic [10:0]      cell_index_i,
  input  logic [COL_W-1:0] col_in_i,
  input  logic [ROW_W-1:0] row_in_i,
  input  logic [3:0]       back_color_i,
  input  logic [3:0]       fore_color_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             status_o,
  output logic [10:0]      cursor_index_o,
  output logic [ROW_W-1:0] cursor_row_o,
  output logic [COL_W-1:0] cursor_col_o,
  output logic [7:0]       cell_char_o,
  output logic [7:0]       cell_attr_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl #(
    .TabWidth (TabWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcw_dpath #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .ch_i           (ch_i),
    .cell_index_i   (cell_index_i),
    .col_in_i       (col_in_i),
    .row_in_i       (row_in_i),
    .back_color_i   (back_color_i),
    .fore_color_i   (fore_color_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .cursor_index_o (cursor_index_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_col_o   (cursor_col_o),
    .cell_char_o    (cell_char_o),
    .cell_attr_o    (cell_attr_o)
  );

endmodule

// ===== sv/tcw_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Used for the cursor row/column split and the newline line number. Uses tcw_pkg.
module tcw_div import tcw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [COL_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [COL_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(DIV_W - 1);

  logic [DIV_W-1:0] dq_q;
  logic [COL_W-1:0] rem_q, dv_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [COL_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, dq_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIV_W-2:0], ge};
      rem_q <= ge ? COL_W'(trial - {1'b0, dv_q}) : COL_W'(trial);
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done lasted more than one cycle");
  a_start_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !done_q) else $error("divider finished right after start");

endmodule

// ===== sv/tcw_dpath.sv =====
// Datapath: cell store, cursor, attribute, configuration and result registers.
// Driven by tcw_ctrl through cmd_t, reports sts_t. Uses tcw_pkg and tcw_div.
module tcw_dpath import tcw_pkg::*; #(
  parameter int MaxCols = MAX_COLS_DEF,
  parameter int MaxRows = MAX_ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [COL_W-1:0] cfg_data_i,
  input  logic [2:0]       func_i,
  input  logic [7:0]       ch_i,
  input  logic [10:0]      cell_index_i,
  input  logic [COL_W-1:0] col_in_i,
  input  logic [ROW_W-1:0] row_in_i,
  input  logic [3:0]       back_color_i,
  input  logic [3:0]       fore_color_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             status_o,
  output logic [10:0]      cursor_index_o,
  output logic [ROW_W-1:0] cursor_row_o,
  output logic [COL_W-1:0] cursor_col_o,
  output logic [7:0]       cell_char_o,
  output logic [7:0]       cell_attr_o
);

  localparam int Cells = MaxCols * MaxRows;
  localparam int AW    = $clog2(Cells);
  localparam int PtrW  = $clog2(Cells + 1);
  localparam int XW    = (PtrW > CUR_W) ? PtrW : CUR_W;

  logic [COL_W-1:0] cols_q, w_eff, cx_q;
  logic [ROW_W-1:0] rows_q, h_eff, cy_q, nl_row_q, mul_b;
  logic [CUR_W-1:0] area_q, prod_q, cur_q, cur_d;
  logic [XW-1:0]    ptr_q, ptr_d, area_x, w_x;
  logic [7:0]       attr_q, ch_q, cell_char_q, cell_attr_q;
  logic [2:0]       func_q;
  logic [10:0]      idx_q;
  logic [3:0]       back_q, fore_q;
  logic             err_q;

  logic [15:0]      mem [Cells];
  logic [15:0]      rdata_q, wdata;
  logic [AW-1:0]    waddr, raddr;
  logic             wen, cur_in_area;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dvd, div_q;
  logic [COL_W-1:0] div_r;

  logic             res_status_q;
  logic [10:0]      res_cur_q;
  logic [ROW_W-1:0] res_row_q;
  logic [COL_W-1:0] res_col_q;
  logic [7:0]       res_char_q, res_attr_q;

  // Out-of-range register values are clamped to the usable range.
  always_comb begin
    w_eff = cols_q;
    if (cols_q == '0) w_eff = COL_W'(1);
    else if (32'(cols_q) > MaxCols) w_eff = COL_W'(MaxCols);
    h_eff = rows_q;
    if (rows_q == '0) h_eff = ROW_W'(1);
    else if (32'(rows_q) > MaxRows) h_eff = ROW_W'(MaxRows);
  end

  assign mul_b  = (func_q == FN_SETXY) ? cy_q : nl_row_q;
  assign area_x = XW'(area_q);
  assign w_x    = XW'(w_eff);

  always_ff @(posedge clk_i) begin
    area_q <= CUR_W'(w_eff * h_eff);
    prod_q <= CUR_W'(w_eff * mul_b);
  end

  always_comb begin
    unique case (cmd_i.cur_op)
      CUR_INC:  cur_d = cur_q + CUR_W'(1);
      CUR_DEC:  cur_d = cur_q - CUR_W'(1);
      CUR_IDX:  cur_d = CUR_W'(idx_q);
      CUR_PROD: cur_d = prod_q;
      CUR_XY:   cur_d = prod_q + CUR_W'(cx_q);
      CUR_MASK: cur_d = {1'b0, cur_q[10:0]};
      default:  cur_d = cur_q;
    endcase
    unique case (cmd_i.ptr_op)
      PTR_ZERO: ptr_d = '0;
      PTR_COLS: ptr_d = w_x;
      PTR_LINE: ptr_d = area_x - w_x;
      PTR_INC:  ptr_d = ptr_q + XW'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
      cur_q  <= '0;
      attr_q <= ATTR_PLAIN;
      ptr_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_COLS) cols_q <= cfg_data_i;
        else rows_q <= cfg_data_i[ROW_W-1:0];
      end
      cur_q <= cur_d;
      ptr_q <= ptr_d;
      if (cmd_i.attr_load) attr_q <= {back_q, fore_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      ch_q   <= ch_i;
      idx_q  <= cell_index_i;
      cx_q   <= col_in_i;
      cy_q   <= row_in_i;
      back_q <= back_color_i;
      fore_q <= fore_color_i;
      err_q  <= 1'b0;
      cell_char_q <= '0;
      cell_attr_q <= '0;
    end else begin
      if (cmd_i.err_set) err_q <= 1'b1;
      if (cmd_i.cell_load) begin
        cell_char_q <= rdata_q[7:0];
        cell_attr_q <= rdata_q[15:8];
      end
    end
    if (cmd_i.nl_row_load)
      nl_row_q <= sts_o.scroll ? h_eff - ROW_W'(1) : ROW_W'(div_q + DIV_W'(1));
    if (cmd_i.out_load) begin
      res_status_q <= err_q;
      res_cur_q    <= cur_q[10:0];
      res_row_q    <= div_q[ROW_W-1:0];
      res_col_q    <= div_r;
      res_char_q   <= cell_char_q;
      res_attr_q   <= cell_attr_q;
    end
  end

  // Cell writes at the cursor are dropped outside the area in use.
  assign cur_in_area = cur_q < area_q;

  always_comb begin
    wen   = 1'b0;
    waddr = AW'(cur_q);
    wdata = {ATTR_PLAIN, CH_NUL};
    unique case (cmd_i.wr_kind)
      WK_CUR_BLANK: wen = cur_in_area;
      WK_CUR_CHAR: begin
        wen   = cur_in_area;
        wdata = {attr_q, (ch_q == CH_TAB) ? CH_SPACE : ch_q};
      end
      WK_CUR_MARK: begin
        wen   = cur_in_area;
        wdata = {ATTR_PLAIN, CH_MARK};
      end
      WK_PTR_BLANK: begin
        wen   = 1'b1;
        waddr = AW'(ptr_q);
        wdata = {ATTR_PLAIN, CH_SPACE};
      end
      WK_PTR_COPY: begin
        wen   = 1'b1;
        waddr = AW'(ptr_q - w_x);
        wdata = rdata_q;
      end
      default: wen = 1'b0;
    endcase
  end

  assign raddr = cmd_i.rd_ptr ? AW'(ptr_q) : AW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign div_start = cmd_i.div_start;
  assign div_dvd   = cmd_i.div_out ? {1'b0, cur_q[10:0]} : cur_q;

  tcw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (w_eff),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  always_comb begin
    sts_o.func         = func_q;
    sts_o.is_nl        = ch_q == CH_NL;
    sts_o.is_tab       = ch_q == CH_TAB;
    sts_o.cur_zero     = cur_q == '0;
    sts_o.idx_bad      = CUR_W'(idx_q) >= area_q;
    sts_o.xy_bad       = (cx_q >= w_eff) || (cy_q >= h_eff);
    sts_o.pp_wrap      = ({1'b0, cur_q} + 13'd1) >= {1'b0, area_q};
    sts_o.scroll       = ({1'b0, div_q} + 13'd1) >= 13'(h_eff);
    sts_o.copy_empty   = w_x >= area_x;
    sts_o.ptr_last     = (ptr_q + XW'(1)) == area_x;
    sts_o.ptr_last_all = (ptr_q + XW'(1)) == XW'(Cells);
    sts_o.div_done     = div_done;
  end

  assign status_o       = res_status_q;
  assign cursor_index_o = res_cur_q;
  assign cursor_row_o   = res_row_q;
  assign cursor_col_o   = res_col_q;
  assign cell_char_o    = res_char_q;
  assign cell_attr_o    = res_attr_q;

endmodule

// ===== sv/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
// Sequences the datapath through cmd_t and reads sts_t. Uses tcw_pkg.
module tcw_ctrl import tcw_pkg::*; #(
  parameter int TabWidth = TAB_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int TW = (TabWidth > 1) ? $clog2(TabWidth) : 1;

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_RD      = 5'd3;
  localparam logic [4:0] S_XY      = 5'd4;
  localparam logic [4:0] S_FSCR    = 5'd5;
  localparam logic [4:0] S_PP_CHAR = 5'd6;
  localparam logic [4:0] S_PP_CHK  = 5'd7;
  localparam logic [4:0] S_PP_MARK = 5'd8;
  localparam logic [4:0] S_NL_DIV  = 5'd9;
  localparam logic [4:0] S_NL_WAIT = 5'd10;
  localparam logic [4:0] S_SCR_RD  = 5'd11;
  localparam logic [4:0] S_SCR_WR  = 5'd12;
  localparam logic [4:0] S_FLINE   = 5'd13;
  localparam logic [4:0] S_NL_MUL  = 5'd14;
  localparam logic [4:0] S_NL_SET  = 5'd15;
  localparam logic [4:0] S_BS_MARK = 5'd16;
  localparam logic [4:0] S_DIV     = 5'd17;
  localparam logic [4:0] S_DIV_W   = 5'd18;
  localparam logic [4:0] S_OUT     = 5'd19;

  logic [4:0]    state_q, state_d;
  logic [TW-1:0] tab_q, tab_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    tab_d   = tab_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.wr_kind = WK_PTR_BLANK;
        if (sts_i.ptr_last_all) state_d = S_IDLE;
        else cmd_o.ptr_op = PTR_INC;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_DIV;
        unique case (sts_i.func)
          FN_PUTC: begin
            if (sts_i.is_nl) begin
              cmd_o.wr_kind = WK_CUR_BLANK;
              state_d       = S_NL_DIV;
            end else begin
              if (sts_i.is_tab) cmd_o.wr_kind = WK_CUR_BLANK;
              tab_d   = '0;
              state_d = S_PP_CHAR;
            end
          end
          FN_BKSP: begin
            if (sts_i.cur_zero) cmd_o.err_set = 1'b1;
            else begin
              cmd_o.wr_kind = WK_CUR_BLANK;
              cmd_o.cur_op  = CUR_DEC;
              state_d       = S_BS_MARK;
            end
          end
          FN_SEEK: begin
            if (sts_i.idx_bad) cmd_o.err_set = 1'b1;
            else cmd_o.cur_op = CUR_IDX;
          end
          FN_SETXY: begin
            if (sts_i.xy_bad) cmd_o.err_set = 1'b1;
            else state_d = S_XY;
          end
          FN_COLOR: cmd_o.attr_load = 1'b1;
          FN_CLS: begin
            cmd_o.ptr_op = PTR_ZERO;
            state_d      = S_FSCR;
          end
          FN_READ: begin
            if (sts_i.idx_bad) cmd_o.err_set = 1'b1;
            else state_d = S_RD;
          end
          default: state_d = S_DIV;
        endcase
      end
      S_RD: begin
        cmd_o.cell_load = 1'b1;
        state_d         = S_DIV;
      end
      S_XY: begin
        cmd_o.cur_op = CUR_XY;
        state_d      = S_DIV;
      end
      S_FSCR: begin
        cmd_o.wr_kind = WK_PTR_BLANK;
        if (sts_i.ptr_last) state_d = S_DIV;
        else cmd_o.ptr_op = PTR_INC;
      end
      S_PP_CHAR: begin
        cmd_o.wr_kind = WK_CUR_CHAR;
        cmd_o.cur_op  = CUR_INC;
        state_d       = S_PP_CHK;
      end
      S_PP_CHK: state_d = sts_i.pp_wrap ? S_NL_DIV : S_PP_MARK;
      S_PP_MARK: begin
        cmd_o.wr_kind = WK_CUR_MARK;
        if (sts_i.is_tab && (32'(tab_q) < TabWidth - 1)) begin
          tab_d   = tab_q + TW'(1);
          state_d = S_PP_CHAR;
        end else begin
          state_d = S_DIV;
        end
      end
      S_NL_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_NL_WAIT;
      end
      S_NL_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.nl_row_load = 1'b1;
          if (!sts_i.scroll) state_d = S_NL_MUL;
          else if (sts_i.copy_empty) begin
            cmd_o.ptr_op = PTR_LINE;
            state_d      = S_FLINE;
          end else begin
            cmd_o.ptr_op = PTR_COLS;
            state_d      = S_SCR_RD;
          end
        end
      end
      S_SCR_RD: begin
        cmd_o.rd_ptr = 1'b1;
        state_d      = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd_o.wr_kind = WK_PTR_COPY;
        if (sts_i.ptr_last) begin
          cmd_o.ptr_op = PTR_LINE;
          state_d      = S_FLINE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          state_d      = S_SCR_RD;
        end
      end
      S_FLINE: begin
        cmd_o.wr_kind = WK_PTR_BLANK;
        if (sts_i.ptr_last) state_d = S_NL_MUL;
        else cmd_o.ptr_op = PTR_INC;
      end
      S_NL_MUL: state_d = S_NL_SET;
      S_NL_SET: begin
        cmd_o.cur_op = CUR_PROD;
        state_d      = sts_i.is_nl ? S_DIV : S_PP_MARK;
      end
      S_BS_MARK: begin
        cmd_o.wr_kind = WK_CUR_MARK;
        state_d       = S_DIV;
      end
      S_DIV: begin
        cmd_o.cur_op    = CUR_MASK;
        cmd_o.div_start = 1'b1;
        cmd_o.div_out   = 1'b1;
        state_d         = S_DIV_W;
      end
      S_DIV_W: if (sts_i.div_done) state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      tab_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tab_q       <= tab_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DISP)
    else $error("accepted transaction not dispatched");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> cmd_o.wr_kind == WK_NONE)
    else $error("cell write while idle");
  a_out_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> $past(state_q == S_DIV_W) || $past(state_q == S_OUT))
    else $error("result loaded without a finished division");

endmodule
